// ===== hdl/amfx_pkg.sv =====
// shared types, constants and register codes of the audio multi-effect core
`timescale 1ns / 1ps

package amfx_pkg;

  localparam int DEF_HISTORY_DEPTH = 262144;

  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 18;
  localparam int LEN_W      = 19;
  localparam int GAIN_W     = 19;
  localparam int RPOS_W     = 18;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int ACC_W      = 18;
  localparam int DIVD_W     = 35;
  localparam int Q_W        = 17;
  localparam int DIV_STEPS  = 17;
  localparam int DIV_CNT_W  = 5;

  // effect modes
  localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRIPLE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_AMP    = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_DELAY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_LEN     = 3'd5;

  // register reset values
  localparam logic [MODE_W-1:0]  RST_EFFECT_MODE  = MODE_LEFT;
  localparam logic [DELAY_W-1:0] RST_SINGLE_DELAY = 18'd44000;
  localparam logic [DELAY_W-1:0] RST_FIRST_DELAY  = 18'd44100;
  localparam logic [DELAY_W-1:0] RST_SECOND_DELAY = 18'd88200;
  localparam logic [DELAY_W-1:0] RST_THIRD_DELAY  = 18'd131072;
  localparam logic [LEN_W-1:0]   RST_RAMP_LEN     = 19'd131072;

  localparam logic [LEN_W-1:0]  RAMP_MAX = 19'd262144;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 19'd524287;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

  // ceil(2^21 / 5); exact floor division by five for every doubled tap sum
  localparam logic [LEN_W-1:0] TRIPLE_RECIP = 19'd419431;
  localparam int               RECIP_SHIFT  = 21;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       rd;
    logic [1:0] tap_sel;
    logic       wr;
    logic       calc;
    logic       prep;
    logic       step;
    logic       load;
  } amfx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] n_taps;
    logic       use_div;
    logic       div_serial;
    logic       out_busy;
  } amfx_stat_t;

endpackage

// ===== hdl/amfx_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps

module amfx_ram #(
  parameter int WIDTH = amfx_pkg::SAMPLE_W,
  parameter int DEPTH = amfx_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/amfx_ctrl.sv =====
// sequencer for tap reads, history write, arithmetic and divider steps
`timescale 1ns / 1ps

module amfx_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  amfx_pkg::amfx_stat_t stat,
  output amfx_pkg::amfx_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_CALC  = 7'b0001000,
    S_PREP  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } amfx_state_t;

  amfx_state_t state, state_next;
  logic [1:0] tap_cnt, tap_cnt_next;
  logic [amfx_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tap_cnt <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      tap_cnt <= tap_cnt_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    tap_cnt_next = tap_cnt;
    div_cnt_next = div_cnt;
    cmd          = '0;
    s_tready     = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take     = 1'b1;
          tap_cnt_next = '0;
          state_next   = (stat.n_taps != 2'd0) ? S_READ : S_WRITE;
        end
      end
      S_READ: begin
        cmd.rd      = 1'b1;
        cmd.tap_sel = tap_cnt;
        if (tap_cnt == stat.n_taps - 2'd1) begin
          state_next = S_WRITE;
        end else begin
          tap_cnt_next = tap_cnt + 2'd1;
        end
      end
      S_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = stat.use_div ? S_PREP : S_DONE;
      end
      S_PREP: begin
        cmd.prep     = 1'b1;
        div_cnt_next = '0;
        // division by five finishes here, the ramp divisor needs the serial loop
        state_next   = stat.div_serial ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (div_cnt == amfx_pkg::DIV_CNT_W'(amfx_pkg::DIV_STEPS - 1)) begin
          state_next = S_DONE;
        end else begin
          div_cnt_next = div_cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/amfx_dp.sv =====
// datapath: registers, delay line, tap addressing, sums, multiplier and divider
`timescale 1ns / 1ps

module amfx_dp #(
  parameter int HISTORY_DEPTH = amfx_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [amfx_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [amfx_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [amfx_pkg::SAMPLE_W-1:0]   s_tdata,
  input  logic                                   m_tready,
  output logic                                   m_tvalid,
  output logic signed [amfx_pkg::SAMPLE_W-1:0]   m_tdata,
  input  amfx_pkg::amfx_cmd_t                    cmd,
  output amfx_pkg::amfx_stat_t                   stat
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);
  localparam int SW = amfx_pkg::SAMPLE_W;
  localparam int XW = amfx_pkg::ACC_W;
  localparam int RW = 2 * amfx_pkg::LEN_W;

  // delay modulo the depth, binary compare-subtract over the few multiples that fit
  function automatic logic [AW-1:0] reduce_delay(input logic [amfx_pkg::DELAY_W-1:0] d);
    logic [19:0] v;
    v = 20'(d);
    for (int k = 8; k >= 0; k--) begin
      if ((longint'(HISTORY_DEPTH) << k) < 64'sd262144) begin
        if (v >= 20'(longint'(HISTORY_DEPTH) << k)) begin
          v = v - 20'(longint'(HISTORY_DEPTH) << k);
        end
      end
    end
    return AW'(v);
  endfunction

  function automatic logic signed [SW-1:0] sat18(input logic signed [XW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > XW'(amfx_pkg::SAMPLE_MAX)) begin
      r = amfx_pkg::SAMPLE_MAX;
    end else if (v < XW'(amfx_pkg::SAMPLE_MIN)) begin
      r = amfx_pkg::SAMPLE_MIN;
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

  // configuration
  logic [amfx_pkg::MODE_W-1:0] mode;
  logic [AW-1:0] dm_single, dm_first, dm_second, dm_third;
  logic [amfx_pkg::LEN_W-1:0] ramp_len;

  // running state
  logic [AW-1:0] write_pos;
  logic [FW-1:0] fill;
  logic sample_parity;
  logic [amfx_pkg::GAIN_W-1:0] ramp_gain;
  logic ramp_rising;
  logic [amfx_pkg::RPOS_W-1:0] ramp_pos;

  // per-item registers
  logic signed [SW-1:0] x;
  logic signed [XW-1:0] acc;
  logic rd_d, tap_ok_d;
  logic signed [SW-1:0] res;
  logic [amfx_pkg::DIVD_W-1:0] rem;
  logic [amfx_pkg::DIVD_W-1:0] dsh;
  logic [amfx_pkg::LEN_W-1:0] dsr;
  logic [amfx_pkg::Q_W-1:0] q;
  logic neg, ovf;
  logic out_valid;
  logic signed [SW-1:0] out_data;

  // combinational
  logic [AW-1:0] dm_sel, tap_addr;
  logic [AW:0] addr_wide;
  logic [FW-1:0] need;
  logic tap_ok;
  logic [AW-1:0] ram_addr;
  logic [SW-1:0] ram_rdata;
  logic [amfx_pkg::LEN_W-1:0] len_c;
  logic signed [XW-1:0] s_sum, s_adj, h;
  logic signed [amfx_pkg::LEN_W-1:0] v2;
  logic [amfx_pkg::LEN_W-1:0] mag4;
  logic signed [SW:0] xe;
  logic [SW:0] ax;
  logic [35:0] prod;
  logic [RW-1:0] recip_prod;
  logic signed [SW-1:0] direct;
  logic [amfx_pkg::Q_W-1:0] lim;
  logic signed [SW-1:0] div_res;
  logic use_div;
  logic [1:0] n_taps;

  always_comb begin
    case (mode)
      amfx_pkg::MODE_SINGLE: n_taps = 2'd1;
      amfx_pkg::MODE_DOUBLE: n_taps = 2'd2;
      amfx_pkg::MODE_TRIPLE: n_taps = 2'd3;
      default:               n_taps = 2'd0;
    endcase
  end

  assign use_div = (mode == amfx_pkg::MODE_TRIPLE) || (mode == amfx_pkg::MODE_AMP);

  assign stat.n_taps     = n_taps;
  assign stat.use_div    = use_div;
  assign stat.div_serial = (mode == amfx_pkg::MODE_AMP);
  assign stat.out_busy   = out_valid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= amfx_pkg::RST_EFFECT_MODE;
      dm_single <= reduce_delay(amfx_pkg::RST_SINGLE_DELAY);
      dm_first  <= reduce_delay(amfx_pkg::RST_FIRST_DELAY);
      dm_second <= reduce_delay(amfx_pkg::RST_SECOND_DELAY);
      dm_third  <= reduce_delay(amfx_pkg::RST_THIRD_DELAY);
      ramp_len  <= amfx_pkg::RST_RAMP_LEN;
    end else if (cfg_valid) begin
      case (cfg_index)
        amfx_pkg::REG_EFFECT_MODE:  mode <= cfg_data[amfx_pkg::MODE_W-1:0];
        amfx_pkg::REG_SINGLE_DELAY: dm_single <= reduce_delay(cfg_data[amfx_pkg::DELAY_W-1:0]);
        amfx_pkg::REG_FIRST_DELAY:  dm_first <= reduce_delay(cfg_data[amfx_pkg::DELAY_W-1:0]);
        amfx_pkg::REG_SECOND_DELAY: dm_second <= reduce_delay(cfg_data[amfx_pkg::DELAY_W-1:0]);
        amfx_pkg::REG_THIRD_DELAY:  dm_third <= reduce_delay(cfg_data[amfx_pkg::DELAY_W-1:0]);
        amfx_pkg::REG_RAMP_LEN:     ramp_len <= cfg_data[amfx_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // tap addressing; a zero delay reads the slot about to be overwritten
  always_comb begin
    case (cmd.tap_sel)
      2'd0:    dm_sel = (mode == amfx_pkg::MODE_SINGLE) ? dm_single : dm_first;
      2'd1:    dm_sel = dm_second;
      default: dm_sel = dm_third;
    endcase
    if (write_pos >= dm_sel) begin
      addr_wide = {1'b0, write_pos} - {1'b0, dm_sel};
    end else begin
      addr_wide = {1'b0, write_pos} + DEPTH_X - {1'b0, dm_sel};
    end
    tap_addr = addr_wide[AW-1:0];
    need     = (dm_sel == '0) ? FILL_FULL : FW'(dm_sel);
    tap_ok   = fill >= need;
  end

  assign ram_addr = cmd.wr ? write_pos : tap_addr;

  amfx_ram #(
    .WIDTH(SW),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.wr),
    .addr (ram_addr),
    .wdata(x),
    .rdata(ram_rdata)
  );

  // arithmetic for the calc step
  always_comb begin
    if (ramp_len == '0) begin
      len_c = amfx_pkg::LEN_W'(1);
    end else if (ramp_len > amfx_pkg::RAMP_MAX) begin
      len_c = amfx_pkg::RAMP_MAX;
    end else begin
      len_c = ramp_len;
    end

    s_sum = XW'(x) + acc;
    // halve toward zero
    s_adj = s_sum + $signed({{(XW - 1){1'b0}}, s_sum[XW-1]});
    h     = s_adj >>> 1;

    v2   = {s_sum, 1'b0};
    mag4 = s_sum[XW-1] ? amfx_pkg::LEN_W'(-v2) : amfx_pkg::LEN_W'(v2);

    xe   = (SW + 1)'(x);
    ax   = xe[SW] ? (SW + 1)'(-xe) : (SW + 1)'(xe);
    prod = 36'(ax) * 36'(ramp_gain);

    case (mode)
      amfx_pkg::MODE_LEFT:   direct = sample_parity ? amfx_pkg::SAMPLE_MIN : x;
      amfx_pkg::MODE_RIGHT:  direct = sample_parity ? x : amfx_pkg::SAMPLE_MIN;
      amfx_pkg::MODE_SINGLE: direct = sat18(h);
      amfx_pkg::MODE_DOUBLE: direct = sat18(h);
      default:               direct = '0;
    endcase

    lim = neg ? amfx_pkg::Q_W'(32768) : amfx_pkg::Q_W'(32767);
    if (ovf || (q > lim)) begin
      div_res = neg ? amfx_pkg::SAMPLE_MIN : amfx_pkg::SAMPLE_MAX;
    end else begin
      div_res = neg ? SW'(-q) : SW'(q);
    end
  end

  // doubled tap magnitude times the reciprocal of five
  assign recip_prod = RW'(rem[amfx_pkg::LEN_W-1:0]) * RW'(amfx_pkg::TRIPLE_RECIP);

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos     <= '0;
      fill          <= '0;
      sample_parity <= 1'b0;
      ramp_gain     <= '0;
      ramp_rising   <= 1'b1;
      ramp_pos      <= '0;
    end else if (cmd.calc) begin
      write_pos     <= (write_pos == AW'(HISTORY_DEPTH - 1)) ? '0 : write_pos + 1'b1;
      fill          <= (fill == FILL_FULL) ? fill : fill + 1'b1;
      sample_parity <= ~sample_parity;
      if (ramp_rising) begin
        if (ramp_gain != amfx_pkg::GAIN_MAX) begin
          ramp_gain <= ramp_gain + 1'b1;
        end
      end else if (ramp_gain != '0) begin
        ramp_gain <= ramp_gain - 1'b1;
      end
      if ({1'b0, ramp_pos} + 1'b1 >= len_c) begin
        ramp_pos    <= '0;
        ramp_rising <= ~ramp_rising;
      end else begin
        ramp_pos <= ramp_pos + 1'b1;
      end
    end
  end

  // read data lands in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_d     <= 1'b0;
      tap_ok_d <= 1'b0;
    end else begin
      rd_d     <= cmd.rd;
      tap_ok_d <= tap_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x   <= s_tdata;
      acc <= '0;
    end else if (rd_d && tap_ok_d) begin
      acc <= acc + XW'(signed'(ram_rdata));
    end

    if (cmd.calc) begin
      res <= direct;
      if (mode == amfx_pkg::MODE_TRIPLE) begin
        rem <= amfx_pkg::DIVD_W'(mag4);
        neg <= s_sum[XW-1];
      end else begin
        rem <= prod[amfx_pkg::DIVD_W-1:0];
        neg <= x[SW-1];
        dsr <= len_c;
      end
    end

    if (cmd.prep) begin
      if (mode == amfx_pkg::MODE_TRIPLE) begin
        ovf <= 1'b0;
        q   <= recip_prod[amfx_pkg::RECIP_SHIFT +: amfx_pkg::Q_W];
      end else begin
        ovf <= {1'b0, rem} >= {dsr, {amfx_pkg::Q_W{1'b0}}};
        dsh <= {dsr, {(amfx_pkg::Q_W - 1){1'b0}}};
        q   <= '0;
      end
    end else if (cmd.step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[amfx_pkg::Q_W-2:0], 1'b1};
      end else begin
        q   <= {q[amfx_pkg::Q_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= use_div ? div_res : res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== hdl/audio_multi_effect_core.sv =====
// top level of the audio multi-effect core
//
//  channel  direction  handshake             payload
//  s_*      in         s_tvalid / s_tready   s_tdata   = sample_in
//  m_*      out        m_tvalid / m_tready   m_tdata   = sample_out
//  cfg_*    in         cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// an item passes through idle, one read per tap, the history write, calc and done:
// each tap read and the history write use the single ram port in turn.
// triple echo adds a prep step for the reciprocal multiply by 1/5; amplitude loop
// adds prep and then the serial divider, which yields one quotient bit per cycle.
// reset clears control state at once; the delay line is not swept, a fill count masks
// taps that reach past the first sample. a stalled output holds the result register and
// the next item may be taken meanwhile; cfg_ready is always high.
`timescale 1ns / 1ps

module audio_multi_effect_core #(
  parameter int HISTORY_DEPTH = amfx_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic signed [amfx_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic signed [amfx_pkg::SAMPLE_W-1:0] m_tdata,   // [15:0] sample_out
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [amfx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [amfx_pkg::CFG_DATA_W-1:0]      cfg_data
);

  amfx_pkg::amfx_cmd_t  cmd;
  amfx_pkg::amfx_stat_t stat;

  assign cfg_ready = 1'b1;

  amfx_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  amfx_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== tb/audio_multi_effect_core_test.sv =====
// self-checking testbench for the audio multi-effect core
`timescale 1ns / 1ps

module audio_multi_effect_core_test;

  localparam int HIST_DEPTH  = amfx_pkg::DEF_HISTORY_DEPTH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1590;
  localparam logic [amfx_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [amfx_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic [amfx_pkg::DELAY_W-1:0] DELAY_TOP = 18'd262143;
  localparam logic [amfx_pkg::LEN_W-1:0]   LEN_TOP   = 19'd524287;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  s_tvalid = 1'b0;
  logic                                  s_tready;
  logic signed [amfx_pkg::SAMPLE_W-1:0]  s_tdata = '0;
  logic                                  m_tvalid;
  logic                                  m_tready = 1'b0;
  logic signed [amfx_pkg::SAMPLE_W-1:0]  m_tdata;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [amfx_pkg::CFG_IDX_W-1:0]        cfg_index = amfx_pkg::REG_EFFECT_MODE;
  logic [amfx_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

  audio_multi_effect_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [15:0] sample_in
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [15:0] sample_out
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the register file
  logic [amfx_pkg::MODE_W-1:0]  cur_mode   = amfx_pkg::RST_EFFECT_MODE;
  logic [amfx_pkg::DELAY_W-1:0] cur_single = amfx_pkg::RST_SINGLE_DELAY;
  logic [amfx_pkg::DELAY_W-1:0] cur_first  = amfx_pkg::RST_FIRST_DELAY;
  logic [amfx_pkg::DELAY_W-1:0] cur_second = amfx_pkg::RST_SECOND_DELAY;
  logic [amfx_pkg::DELAY_W-1:0] cur_third  = amfx_pkg::RST_THIRD_DELAY;
  logic [amfx_pkg::LEN_W-1:0]   cur_len    = amfx_pkg::RST_RAMP_LEN;

  // predicted state of the block
  bit [amfx_pkg::SAMPLE_W-1:0] delay_line [HIST_DEPTH];
  int                          line_pos   = 0;
  bit                          odd_slot   = 1'b0;
  bit [amfx_pkg::GAIN_W-1:0]   gain_now   = '0;
  bit                          gain_up    = 1'b1;
  longint                      ramp_count = 0;

  logic signed [amfx_pkg::SAMPLE_W-1:0] expected_samples [$];
  logic signed [amfx_pkg::SAMPLE_W-1:0] want;

  int     mismatches = 0;
  int     samples_sent = 0;
  int     samples_checked = 0;
  int     settings_used = 0;
  bit [7:0] modes_seen = '0;
  int     cycles = 0;
  bit     tx_idle_on = 1'b0;
  bit     rx_idle_on = 1'b0;
  int     hold_len_req = 0;
  int     hold_req_id = 0;
  int     hold_ack_id = 0;
  int     rx_wait = 0;

  function automatic longint delay_tap(input logic [amfx_pkg::DELAY_W-1:0] d);
    int idx;
    idx = (line_pos + HIST_DEPTH - (int'(d) % HIST_DEPTH)) % HIST_DEPTH;
    return longint'($signed(delay_line[idx]));
  endfunction

  function automatic logic signed [amfx_pkg::SAMPLE_W-1:0] clip16(input longint v);
    if (v > 32767) return amfx_pkg::SAMPLE_MAX;
    if (v < -32768) return amfx_pkg::SAMPLE_MIN;
    return amfx_pkg::SAMPLE_W'(v);
  endfunction

  // output of the current effect, then advance delay line, parity and ramp
  function automatic logic signed [amfx_pkg::SAMPLE_W-1:0] apply_effect(
    input logic signed [amfx_pkg::SAMPLE_W-1:0] x
  );
    longint eff_len;
    longint sum;
    logic signed [amfx_pkg::SAMPLE_W-1:0] y;
    eff_len = (cur_len == 0) ? 1 :
              (cur_len > amfx_pkg::RAMP_MAX) ? longint'(amfx_pkg::RAMP_MAX) : longint'(cur_len);
    case (cur_mode)
      amfx_pkg::MODE_LEFT:   y = odd_slot ? amfx_pkg::SAMPLE_MIN : x;
      amfx_pkg::MODE_RIGHT:  y = odd_slot ? x : amfx_pkg::SAMPLE_MIN;
      amfx_pkg::MODE_SINGLE: y = clip16((longint'(x) + delay_tap(cur_single)) / 2);
      amfx_pkg::MODE_DOUBLE: begin
        sum = longint'(x) + delay_tap(cur_first) + delay_tap(cur_second);
        y = clip16(sum / 2);
      end
      amfx_pkg::MODE_TRIPLE: begin
        sum = longint'(x) + delay_tap(cur_first) + delay_tap(cur_second)
              + delay_tap(cur_third);
        y = clip16((sum * 2) / 5);
      end
      amfx_pkg::MODE_AMP:    y = clip16((longint'(x) * longint'(gain_now)) / eff_len);
      default:               y = '0;
    endcase
    delay_line[line_pos] = x;
    line_pos = (line_pos + 1) % HIST_DEPTH;
    odd_slot = !odd_slot;
    if (gain_up) begin
      if (gain_now < amfx_pkg::GAIN_MAX) gain_now = gain_now + 1'b1;
    end else if (gain_now > 0) begin
      gain_now = gain_now - 1'b1;
    end
    if (ramp_count + 1 >= eff_len) begin
      ramp_count = 0;
      gain_up = !gain_up;
    end else begin
      ramp_count = ramp_count + 1;
    end
    return y;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [amfx_pkg::SAMPLE_W-1:0] random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return amfx_pkg::SAMPLE_MAX;
    if (r < 8) return amfx_pkg::SAMPLE_MIN;
    if (r < 11) return '0;
    if (r < 14) return -16'sd1;
    return amfx_pkg::SAMPLE_W'($urandom);
  endfunction

  function automatic logic [amfx_pkg::DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return amfx_pkg::DELAY_W'($urandom_range(1, 64));
    if (r < 60) begin
      return amfx_pkg::DELAY_W'($urandom_range(1, (samples_sent > 1) ? samples_sent : 1));
    end
    if (r < 70) return '0;
    if (r < 80) return DELAY_TOP;
    return amfx_pkg::DELAY_W'($urandom_range(0, 262143));
  endfunction

  task automatic report_error(input string what, input bit has_want,
                              input logic signed [amfx_pkg::SAMPLE_W-1:0] exp_v,
                              input logic signed [amfx_pkg::SAMPLE_W-1:0] act_v);
    mismatches++;
    if (mismatches <= 10) begin
      if (has_want)
        $display("[%0t] %s: sample_out expected %0d, got %0d", $time, what, exp_v, act_v);
      else
        $display("[%0t] %s: sample_out %0d", $time, what, act_v);
    end
  endtask

  // one register write, starting and ending on a falling edge
  task automatic write_reg(input logic [amfx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [amfx_pkg::CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      amfx_pkg::REG_EFFECT_MODE:  cur_mode   = value[amfx_pkg::MODE_W-1:0];
      amfx_pkg::REG_SINGLE_DELAY: cur_single = value[amfx_pkg::DELAY_W-1:0];
      amfx_pkg::REG_FIRST_DELAY:  cur_first  = value[amfx_pkg::DELAY_W-1:0];
      amfx_pkg::REG_SECOND_DELAY: cur_second = value[amfx_pkg::DELAY_W-1:0];
      amfx_pkg::REG_THIRD_DELAY:  cur_third  = value[amfx_pkg::DELAY_W-1:0];
      amfx_pkg::REG_RAMP_LEN:     cur_len    = value[amfx_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [amfx_pkg::MODE_W-1:0] mode,
                            input logic [amfx_pkg::DELAY_W-1:0] d0,
                            input logic [amfx_pkg::DELAY_W-1:0] d1,
                            input logic [amfx_pkg::DELAY_W-1:0] d2,
                            input logic [amfx_pkg::DELAY_W-1:0] d3,
                            input logic [amfx_pkg::LEN_W-1:0] len);
    write_reg(amfx_pkg::REG_EFFECT_MODE, amfx_pkg::CFG_DATA_W'(mode));
    write_reg(amfx_pkg::REG_SINGLE_DELAY, amfx_pkg::CFG_DATA_W'(d0));
    write_reg(amfx_pkg::REG_FIRST_DELAY, amfx_pkg::CFG_DATA_W'(d1));
    write_reg(amfx_pkg::REG_SECOND_DELAY, amfx_pkg::CFG_DATA_W'(d2));
    write_reg(amfx_pkg::REG_THIRD_DELAY, amfx_pkg::CFG_DATA_W'(d3));
    write_reg(amfx_pkg::REG_RAMP_LEN, amfx_pkg::CFG_DATA_W'(len));
    cfg_valid = 1'b0;
    settings_used++;
    modes_seen[mode] = 1'b1;
  endtask

  // offers one item; valid stays high on return, so the next item can follow without a gap
  task automatic send_sample(input logic signed [amfx_pkg::SAMPLE_W-1:0] x);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = x;
    do @(posedge clk); while (!s_tready);
    expected_samples = {expected_samples, apply_effect(x)};
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req_id != hold_ack_id) begin
      hold_ack_id = hold_req_id;
      rx_wait = hold_len_req;
    end
    if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else if (rx_idle_on && $urandom_range(0, 99) < 35) begin
      m_tready <= 1'b0;
      rx_wait = idle_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        report_error("item with nothing pending", 1'b0, '0, m_tdata);
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (m_tdata !== want) report_error("mismatch", 1'b1, want, m_tdata);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycles, expected_samples.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // left and right selection, first from the reset settings
  task automatic test_channel_select();
    send_sample(amfx_pkg::SAMPLE_MAX);
    send_sample(amfx_pkg::SAMPLE_MIN);
    wait_idle();
    set_config(amfx_pkg::MODE_RIGHT, amfx_pkg::RST_SINGLE_DELAY, amfx_pkg::RST_FIRST_DELAY,
               amfx_pkg::RST_SECOND_DELAY, amfx_pkg::RST_THIRD_DELAY,
               amfx_pkg::RST_RAMP_LEN);
    send_sample('0);
    send_sample(-16'sd1);
    wait_idle();
  endtask

  // one tap; zero delay and the longest delay read the cleared line
  task automatic test_single_echo();
    set_config(amfx_pkg::MODE_SINGLE, 18'd1, amfx_pkg::RST_FIRST_DELAY,
               amfx_pkg::RST_SECOND_DELAY, amfx_pkg::RST_THIRD_DELAY,
               amfx_pkg::RST_RAMP_LEN);
    send_sample(amfx_pkg::SAMPLE_MAX);
    send_sample(amfx_pkg::SAMPLE_MAX);
    send_sample(amfx_pkg::SAMPLE_MIN);
    wait_idle();
    set_config(amfx_pkg::MODE_SINGLE, '0, amfx_pkg::RST_FIRST_DELAY,
               amfx_pkg::RST_SECOND_DELAY, amfx_pkg::RST_THIRD_DELAY,
               amfx_pkg::RST_RAMP_LEN);
    send_sample(amfx_pkg::SAMPLE_MIN);
    wait_idle();
    set_config(amfx_pkg::MODE_SINGLE, DELAY_TOP, amfx_pkg::RST_FIRST_DELAY,
               amfx_pkg::RST_SECOND_DELAY, amfx_pkg::RST_THIRD_DELAY,
               amfx_pkg::RST_RAMP_LEN);
    send_sample(16'sd12345);
    wait_idle();
  endtask

  // two taps driven into positive saturation, then three taps fed negative samples
  task automatic test_multi_tap();
    set_config(amfx_pkg::MODE_DOUBLE, 18'd1, 18'd1, 18'd2, 18'd3, amfx_pkg::RST_RAMP_LEN);
    send_sample(amfx_pkg::SAMPLE_MAX);
    send_sample(amfx_pkg::SAMPLE_MAX);
    send_sample(amfx_pkg::SAMPLE_MAX);
    wait_idle();
    set_config(amfx_pkg::MODE_TRIPLE, 18'd1, 18'd1, 18'd2, 18'd3, amfx_pkg::RST_RAMP_LEN);
    send_sample(amfx_pkg::SAMPLE_MIN);
    send_sample(amfx_pkg::SAMPLE_MIN);
    send_sample(-16'sd3);
    wait_idle();
  endtask

  // gain ramp with length of one, length zero and an oversized length
  task automatic test_amplitude_loop();
    set_config(amfx_pkg::MODE_AMP, 18'd1, 18'd1, 18'd2, 18'd3, 19'd1);
    send_sample(amfx_pkg::SAMPLE_MAX);
    send_sample(amfx_pkg::SAMPLE_MIN);
    send_sample(16'sd5);
    wait_idle();
    set_config(amfx_pkg::MODE_AMP, 18'd1, 18'd1, 18'd2, 18'd3, '0);
    send_sample(amfx_pkg::SAMPLE_MIN);
    wait_idle();
    set_config(amfx_pkg::MODE_AMP, 18'd1, 18'd1, 18'd2, 18'd3, LEN_TOP);
    send_sample(amfx_pkg::SAMPLE_MAX);
    wait_idle();
  endtask

  task automatic test_spare_modes();
    set_config(MODE_SPARE_LO, 18'd1, 18'd1, 18'd2, 18'd3, 19'd4);
    send_sample(amfx_pkg::SAMPLE_MAX);
    wait_idle();
    set_config(MODE_SPARE_HI, 18'd1, 18'd1, 18'd2, 18'd3, 19'd4);
    send_sample(amfx_pkg::SAMPLE_MIN);
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering items back to back
  task automatic test_output_backpressure();
    int i;
    set_config(amfx_pkg::MODE_DOUBLE, 18'd1, 18'd3, 18'd7, 18'd11, 19'd16);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_len_req = 400;
    hold_req_id++;
    for (i = 0; i < 40; i++) send_sample(random_sample());
    wait_idle();
  endtask

  task automatic test_random_settings();
    int phase;
    int n;
    int i;
    int r;
    logic [amfx_pkg::MODE_W-1:0] mode;
    logic [amfx_pkg::LEN_W-1:0] len;
    phase = 0;
    while (samples_sent < RANDOM_ITEMS + 62) begin
      r = $urandom_range(0, 31);
      mode = (r < 30) ? amfx_pkg::MODE_W'(r % 6) : amfx_pkg::MODE_W'(6 + r - 30);
      r = $urandom_range(0, 99);
      if (r < 35)      len = amfx_pkg::LEN_W'($urandom_range(1, 8));
      else if (r < 60) len = amfx_pkg::LEN_W'($urandom_range(9, 400));
      else if (r < 65) len = '0;
      else if (r < 70) len = amfx_pkg::RAMP_MAX;
      else if (r < 78) len = amfx_pkg::LEN_W'($urandom_range(262145, 524287));
      else             len = amfx_pkg::LEN_W'($urandom_range(0, 524287));
      set_config(mode, pick_delay(), pick_delay(), pick_delay(), pick_delay(), len);
      // every fourth phase runs with no idling on either side
      tx_idle_on = (phase % 4 != 0) && (phase % 4 != 2 || $urandom_range(0, 1));
      rx_idle_on = (phase % 4 != 0) && (phase % 4 != 1 || $urandom_range(0, 1));
      n = $urandom_range(20, 80);
      for (i = 0; i < n; i++) send_sample(random_sample());
      wait_idle();
      phase++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    modes_seen[amfx_pkg::RST_EFFECT_MODE] = 1'b1;

    test_channel_select();
    test_single_echo();
    test_multi_tap();
    test_amplitude_loop();
    test_spare_modes();
    test_output_backpressure();
    test_random_settings();

    wait_idle();
    repeat (60) @(posedge clk);
    if (expected_samples.size() != 0) mismatches += expected_samples.size();

    $display("%0d samples sent and %0d results compared under %0d register settings",
             samples_sent, samples_checked, settings_used);
    $display("effect modes exercised (bit per mode, 7..0): %b, mismatches: %0d",
             modes_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/amfx_pkg.sv
hdl/amfx_ram.sv
hdl/amfx_ctrl.sv
hdl/amfx_dp.sv
hdl/audio_multi_effect_core.sv
tb/audio_multi_effect_core_test.sv
